/* sv/csp_pkg.sv */
// ----------------------------------------------------------------------------
// csp_pkg
// shared widths, sepia coefficient table and fixed-point helpers
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int PIX_W             = 8;
    localparam int GAIN_W            = 12;
    localparam int FRAC_BITS_DEFAULT = 10;
    localparam int NUM_CH            = 3;
    localparam int GAIN_MAX          = (1 << GAIN_W) - 1;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef t_pix [NUM_CH-1:0]        t_rgb;

    // sepia matrix in thousandths, row = output channel, column = input channel
    localparam int SEPIA_MILLI [NUM_CH][NUM_CH] = '{
        '{393, 769, 189},
        '{349, 686, 168},
        '{272, 534, 131}
    };

    // thousandths to unsigned Q0.frac, halves rounded up
    function automatic int coef_q(input int milli, input int frac);
        int scaled;
        scaled = (milli << frac) + 500;
        return scaled / 1000;
    endfunction

    // 1.1025 in unsigned Q2.frac, saturated to the register range
    function automatic int gain_reset(input int frac);
        int raw;
        raw = ((11025 << frac) + 5000) / 10000;
        return (raw > GAIN_MAX) ? GAIN_MAX : raw;
    endfunction

endpackage

/* sv/csp_gain_stage.sv */
// ----------------------------------------------------------------------------
// csp_gain_stage
// first pipeline stage: multiplies each channel by the contrast gain
// ----------------------------------------------------------------------------
module csp_gain_stage (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  logic                                              i_valid,
    input  csp_pkg::t_rgb                                     i_pix,
    input  csp_pkg::t_gain                                    i_gain,
    output logic                                              o_valid,
    output logic [csp_pkg::NUM_CH-1:0][csp_pkg::PIX_W+csp_pkg::GAIN_W-1:0] o_prod
);
    import csp_pkg::*;

    localparam int PROD_W = PIX_W + GAIN_W;

    logic                           r_valid;
    logic [NUM_CH-1:0][PROD_W-1:0]  r_prod;
    logic [NUM_CH-1:0][PROD_W-1:0]  n_prod;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_prod[c] = PROD_W'(i_pix[c]) * PROD_W'(i_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

/* sv/csp_matrix_stage.sv */
// ----------------------------------------------------------------------------
// csp_matrix_stage
// second pipeline stage: scales and saturates the adjusted channels, then
// forms the nine sepia coefficient products
// ----------------------------------------------------------------------------
module csp_matrix_stage #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                                           i_clk,
    input  logic                                                           i_rst_n,
    input  logic                                                           i_en,
    input  logic                                                           i_valid,
    input  logic [csp_pkg::NUM_CH-1:0][csp_pkg::PIX_W+csp_pkg::GAIN_W-1:0] i_prod,
    output logic                                                           o_valid,
    output logic [csp_pkg::NUM_CH-1:0][csp_pkg::NUM_CH-1:0][csp_pkg::PIX_W+FRAC_BITS-1:0]
                                                                           o_term
);
    import csp_pkg::*;

    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int TERM_W = PIX_W + FRAC_BITS;

    logic                                         r_valid;
    logic [NUM_CH-1:0][NUM_CH-1:0][TERM_W-1:0]    r_term;
    logic [NUM_CH-1:0][NUM_CH-1:0][TERM_W-1:0]    n_term;
    logic [NUM_CH-1:0][PROD_W-1:0]                shifted;
    t_rgb                                         adj;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            shifted[c] = i_prod[c] >> FRAC_BITS;
            adj[c]     = (shifted[c] > PROD_W'(255)) ? t_pix'(255) : shifted[c][PIX_W-1:0];
        end
        for (int o = 0; o < NUM_CH; o++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                n_term[o][c] = TERM_W'(adj[c])
                             * TERM_W'(coef_q(SEPIA_MILLI[o][c], FRAC_BITS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_valid = r_valid;
    assign o_term  = r_term;

endmodule

/* sv/csp_sum_stage.sv */
// ----------------------------------------------------------------------------
// csp_sum_stage
// third pipeline stage: sums each sepia row, drops the fraction and
// saturates into the output register
// ----------------------------------------------------------------------------
module csp_sum_stage #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                                           i_clk,
    input  logic                                                           i_rst_n,
    input  logic                                                           i_en,
    input  logic                                                           i_valid,
    input  logic [csp_pkg::NUM_CH-1:0][csp_pkg::NUM_CH-1:0][csp_pkg::PIX_W+FRAC_BITS-1:0]
                                                                           i_term,
    output logic                                                           o_valid,
    output csp_pkg::t_rgb                                                  o_pix
);
    import csp_pkg::*;

    localparam int TERM_W = PIX_W + FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    logic                          r_valid;
    t_rgb                          r_pix;
    t_rgb                          n_pix;
    logic [NUM_CH-1:0][SUM_W-1:0]  sum;
    logic [NUM_CH-1:0][SUM_W-1:0]  shifted;

    always_comb begin
        for (int o = 0; o < NUM_CH; o++) begin
            sum[o]     = SUM_W'(i_term[o][0]) + SUM_W'(i_term[o][1]) + SUM_W'(i_term[o][2]);
            shifted[o] = sum[o] >> FRAC_BITS;
            n_pix[o]   = (shifted[o] > SUM_W'(255)) ? t_pix'(255) : shifted[o][PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

/* sv/contrast_sepia_pixel_filter_core.sv */
// ----------------------------------------------------------------------------
// contrast_sepia_pixel_filter_core
// contrast gain followed by the sepia color matrix, one pixel per clock while the output is not stalled
//
// input channel: i_valid / o_ready with i_red_in, i_green_in, i_blue_in;
// a transfer happens on a rising edge with both high
// output channel: o_valid / i_ready with o_red_out, o_green_out, o_blue_out
// config: i_cfg_we writes i_cfg_data into the contrast gain (unsigned
// Q2.FRAC_BITS), change it only while the pipeline is empty
// path: after the input transfer a pixel passes through the gain
// multiply, coefficient multiply and row sum registers, in that order,
// before o_valid rises
// throughput: one pixel per cycle; all three stages advance together
// when the output register is empty or being taken
// stall: with i_ready low and o_valid high the whole pipeline holds and
// o_ready drops, nothing is lost or repeated
// reset: synchronous active-low i_rst_n clears all valid bits and loads
// the gain with 1.1025
// ----------------------------------------------------------------------------
module contrast_sepia_pixel_filter_core #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [csp_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [csp_pkg::PIX_W-1:0]     i_red_in,
    input  logic [csp_pkg::PIX_W-1:0]     i_green_in,
    input  logic [csp_pkg::PIX_W-1:0]     i_blue_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [csp_pkg::PIX_W-1:0]     o_red_out,
    output logic [csp_pkg::PIX_W-1:0]     o_green_out,
    output logic [csp_pkg::PIX_W-1:0]     o_blue_out
);
    import csp_pkg::*;

    localparam int    PROD_W     = PIX_W + GAIN_W;
    localparam int    TERM_W     = PIX_W + FRAC_BITS;
    localparam t_gain GAIN_RESET = t_gain'(gain_reset(FRAC_BITS));

    t_gain                                      r_gain;
    logic                                       en;
    t_rgb                                       pix_in;
    t_rgb                                       pix_out;
    logic                                       s1_valid;
    logic                                       s2_valid;
    logic [NUM_CH-1:0][PROD_W-1:0]              s1_prod;
    logic [NUM_CH-1:0][NUM_CH-1:0][TERM_W-1:0]  s2_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_data;
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign pix_in  = {i_blue_in, i_green_in, i_red_in};

    csp_gain_stage u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pix   (pix_in),
        .i_gain  (r_gain),
        .o_valid (s1_valid),
        .o_prod  (s1_prod)
    );

    csp_matrix_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_prod  (s1_prod),
        .o_valid (s2_valid),
        .o_term  (s2_term)
    );

    csp_sum_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_valid),
        .i_term  (s2_term),
        .o_valid (o_valid),
        .o_pix   (pix_out)
    );

    assign o_red_out   = pix_out[0];
    assign o_green_out = pix_out[1];
    assign o_blue_out  = pix_out[2];

endmodule
